FILE: rtl/mono_framebuffer_draw_engine_defines.svh
// Assertion macros used by the draw engine controller.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MFDE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfde: same-cycle check failed");

// Next-cycle implication.
`define MFDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfde: next-cycle check failed");

`endif

FILE: rtl/mfde_pkg.sv
// Shared types, command codes, font table and helpers of the draw engine.
`default_nettype none
package mfde_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_PIXEL   = 3'd1,
    CMD_FILL    = 3'd2,
    CMD_OUTLINE = 3'd3,
    CMD_CHAR    = 3'd4,
    CMD_ORIGIN  = 3'd5,
    CMD_TEXT    = 3'd6,
    CMD_READ    = 3'd7
  } cmd_t;

  localparam int          CRD_W        = 18;
  localparam int          GLYPH_COUNT  = 95;
  localparam logic [2:0]  GLYPH_LCOL   = 3'd4;
  localparam logic [2:0]  GLYPH_LROW   = 3'd6;
  localparam logic [1:0]  OUTLINE_LAST = 2'd3;
  localparam logic [7:0]  CODE_FIRST   = 8'h20;
  localparam logic [7:0]  CODE_LAST    = 8'h7E;
  localparam logic [7:0]  CODE_SUBST   = 8'h3F;
  localparam logic [7:0]  CODE_NEWLINE = 8'h0A;

  typedef struct packed {
    logic       load;
    logic       box_calc;
    logic       clip;
    logic       mem_rd;
    logic       mem_wr;
    logic       adv;
    logic       rd_cmd;
    logic       out_load;
    logic [2:0] gcol;
    logic [2:0] grow;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic glyph_skip;
    logic box_empty;
    logic iter_last;
  } dp_stat_t;

  // Five columns per glyph, column 0 in the top byte; bit 0 is the top row.
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  function automatic logic [7:0] font_column(logic [6:0] g, logic [2:0] c);
    logic [39:0] e;
    e = FONT_ROM[g];
    unique case (c)
      3'd0:    font_column = e[39:32];
      3'd1:    font_column = e[31:24];
      3'd2:    font_column = e[23:16];
      3'd3:    font_column = e[15:8];
      default: font_column = e[7:0];
    endcase
  endfunction

  function automatic logic [6:0] glyph_index(logic [7:0] code);
    logic [7:0] c;
    c = (code < CODE_FIRST || code > CODE_LAST) ? CODE_SUBST : code;
    glyph_index = 7'(c - CODE_FIRST);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [CRD_W-1:0] v);
    if (v > 18'sd32767)       sat16 = 16'sh7FFF;
    else if (v < -18'sd32768) sat16 = 16'sh8000;
    else                      sat16 = v[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mfde_dp.sv
// Datapath: request registers, cursor, box geometry and clipping, byte walker, frame RAM.
`default_nettype none
module mfde_dp #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_ADVANCE = 6,
  parameter int LINE_ADVANCE  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mfde_pkg::dp_ctrl_t  ctl,
  output mfde_pkg::dp_stat_t       st,
  input  wire logic [2:0]          in_cmd,
  input  wire logic signed [15:0]  in_x_pos,
  input  wire logic signed [15:0]  in_y_pos,
  input  wire logic signed [15:0]  in_rect_width,
  input  wire logic signed [15:0]  in_rect_height,
  input  wire logic [7:0]          in_char_code,
  input  wire logic [7:0]          in_scale,
  input  wire logic                in_color,
  input  wire logic [9:0]          in_read_addr,
  output logic [7:0]               out_read_data
);
  import mfde_pkg::*;

  localparam int PAGES    = (SCREEN_HEIGHT + 7) / 8;
  localparam int FB_BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW       = $clog2(FB_BYTES);
  localparam int CW       = $clog2(SCREEN_WIDTH);
  localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic signed [CRD_W-1:0] W_S  = CRD_W'(SCREEN_WIDTH);
  localparam logic signed [CRD_W-1:0] H_S  = CRD_W'(SCREEN_HEIGHT);
  localparam logic signed [CRD_W-1:0] PH_S = CRD_W'(PAGES * 8);
  localparam logic signed [CRD_W-1:0] ONE  = CRD_W'(1);
  localparam logic signed [CRD_W-1:0] ZERO = '0;

  cmd_t                     cmd_r;
  logic signed [CRD_W-1:0]  x_r, y_r, w_r, h_r, base_x_r, base_y_r;
  logic [7:0]               s_r;
  logic                     color_r;
  logic [6:0]               gidx_r;
  logic [AW-1:0]            rd_addr_r;
  logic                     rd_ok_r;
  logic signed [15:0]       origin_x_r, cursor_x_r, cursor_y_r;
  logic signed [CRD_W-1:0]  bx0_r, bx1_r, by0_r, by1_r;
  logic [CW-1:0]            col_r, xlast_r;
  logic [PW-1:0]            page_r, p0_r, p1_r;
  logic [2:0]               lo_r, hi_r;
  logic [7:0]               q_r;
  logic [7:0]               out_data_r;
  logic [7:0]               mem [FB_BYTES];

  // Request capture and cursor update.
  logic [CRD_W-1:0] gstep, lstep;
  assign gstep = CRD_W'(GLYPH_ADVANCE) * {10'd0, in_scale};
  assign lstep = CRD_W'(LINE_ADVANCE) * {10'd0, in_scale};

  logic [31:0] ra32;
  assign ra32 = 32'(in_read_addr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= CMD_CLEAR;
      origin_x_r <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else if (ctl.load) begin
      cmd_r <= cmd_t'(in_cmd);
      if (cmd_t'(in_cmd) == CMD_ORIGIN) begin
        origin_x_r <= in_x_pos;
        cursor_x_r <= in_x_pos;
        cursor_y_r <= in_y_pos;
      end else if (cmd_t'(in_cmd) == CMD_TEXT) begin
        if (in_char_code == CODE_NEWLINE) begin
          cursor_x_r <= origin_x_r;
          cursor_y_r <= sat16(CRD_W'(cursor_y_r) + $signed(lstep));
        end else begin
          cursor_x_r <= sat16(CRD_W'(cursor_x_r) + $signed(gstep));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r       <= CRD_W'(in_x_pos);
      y_r       <= CRD_W'(in_y_pos);
      w_r       <= CRD_W'(in_rect_width);
      h_r       <= CRD_W'(in_rect_height);
      s_r       <= in_scale;
      color_r   <= in_color;
      gidx_r    <= glyph_index(in_char_code);
      rd_addr_r <= ra32[AW-1:0];
      rd_ok_r   <= ra32 < 32'(FB_BYTES);
      base_x_r  <= (cmd_t'(in_cmd) == CMD_TEXT) ? CRD_W'(cursor_x_r) : CRD_W'(in_x_pos);
      base_y_r  <= (cmd_t'(in_cmd) == CMD_TEXT) ? CRD_W'(cursor_y_r) : CRD_W'(in_y_pos);
    end
  end

  // Raw box of the current drawing step.
  logic [10:0]             cs, rs;
  logic signed [CRD_W-1:0] px, py, sz;
  logic signed [CRD_W-1:0] nx0, nx1, ny0, ny1;
  logic [7:0]              fcol;

  assign cs   = 11'(ctl.gcol) * 11'(s_r);
  assign rs   = 11'(ctl.grow) * 11'(s_r);
  assign sz   = $signed({10'd0, s_r});
  assign px   = base_x_r + $signed({7'd0, cs});
  assign py   = base_y_r + $signed({7'd0, rs});
  assign fcol = font_column(gidx_r, ctl.gcol);

  always_comb begin
    nx0 = ZERO;
    nx1 = ZERO;
    ny0 = ZERO;
    ny1 = ZERO;
    unique case (cmd_r)
      CMD_CLEAR: begin
        nx1 = W_S;
        ny1 = PH_S;
      end
      CMD_PIXEL: begin
        nx0 = x_r;
        nx1 = x_r + ONE;
        ny0 = y_r;
        ny1 = y_r + ONE;
      end
      CMD_FILL: begin
        nx0 = x_r;
        nx1 = x_r + w_r;
        ny0 = y_r;
        ny1 = y_r + h_r;
      end
      CMD_OUTLINE: begin
        unique case (ctl.grow[1:0])
          2'd0: begin
            nx0 = x_r;            nx1 = x_r + w_r;
            ny0 = y_r;            ny1 = y_r + ONE;
          end
          2'd1: begin
            nx0 = x_r;            nx1 = x_r + w_r;
            ny0 = y_r + h_r - ONE; ny1 = y_r + h_r;
          end
          2'd2: begin
            nx0 = x_r;            nx1 = x_r + ONE;
            ny0 = y_r;            ny1 = y_r + h_r;
          end
          default: begin
            nx0 = x_r + w_r - ONE; nx1 = x_r + w_r;
            ny0 = y_r;            ny1 = y_r + h_r;
          end
        endcase
      end
      CMD_CHAR, CMD_TEXT: begin
        nx0 = px;
        nx1 = px + sz;
        ny0 = py;
        ny1 = py + sz;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.box_calc) begin
      bx0_r <= nx0;
      bx1_r <= nx1;
      by0_r <= ny0;
      by1_r <= ny1;
    end
  end

  // Clip against the screen; a clear also covers the unused rows of the last page.
  logic signed [CRD_W-1:0] ylim, cx0, cx1, cy0, cy1, cx1m, cy1m;
  assign ylim = (cmd_r == CMD_CLEAR) ? PH_S : H_S;
  assign cx0  = (bx0_r < ZERO) ? ZERO : bx0_r;
  assign cx1  = (bx1_r > W_S) ? W_S : bx1_r;
  assign cy0  = (by0_r < ZERO) ? ZERO : by0_r;
  assign cy1  = (by1_r > ylim) ? ylim : by1_r;
  assign cx1m = cx1 - ONE;
  assign cy1m = cy1 - ONE;

  always_ff @(posedge clk) begin
    if (ctl.clip) begin
      col_r   <= cx0[CW-1:0];
      xlast_r <= cx1m[CW-1:0];
      page_r  <= cy0[3 +: PW];
      p0_r    <= cy0[3 +: PW];
      p1_r    <= cy1m[3 +: PW];
      lo_r    <= cy0[2:0];
      hi_r    <= cy1m[2:0];
    end else if (ctl.adv) begin
      if (page_r == p1_r) begin
        page_r <= p0_r;
        col_r  <= col_r + CW'(1);
      end else begin
        page_r <= page_r + PW'(1);
      end
    end
  end

  // Byte address, row mask and merged write data.
  logic [31:0]   a32;
  logic [AW-1:0] mem_addr;
  logic [2:0]    lo_e, hi_e;
  logic [7:0]    mask, wdata;
  logic          draw_color;

  assign a32      = 32'(col_r) + 32'(page_r) * 32'(SCREEN_WIDTH);
  assign mem_addr = ctl.rd_cmd ? rd_addr_r : a32[AW-1:0];
  assign lo_e     = (page_r == p0_r) ? lo_r : 3'd0;
  assign hi_e     = (page_r == p1_r) ? hi_r : 3'd7;
  assign draw_color = (cmd_r == CMD_CLEAR) ? 1'b0 : color_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(i) >= lo_e) && (3'(i) <= hi_e);
    end
  end

  assign wdata = draw_color ? (q_r | mask) : (q_r & ~mask);

  always_ff @(posedge clk) begin
    if (ctl.mem_wr) begin
      mem[mem_addr] <= wdata;
    end
    if (ctl.mem_rd) begin
      q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r <= (cmd_r == CMD_READ && rd_ok_r) ? q_r : 8'd0;
    end
  end

  assign out_read_data = out_data_r;

  assign st.cmd        = cmd_r;
  assign st.glyph_skip = (cmd_r == CMD_CHAR || cmd_r == CMD_TEXT) &&
                         (s_r == 8'd0 || !fcol[ctl.grow]);
  assign st.box_empty  = (cx0 >= cx1) || (cy0 >= cy1);
  assign st.iter_last  = (col_r == xlast_r) && (page_r == p1_r);

endmodule
`default_nettype wire

FILE: rtl/mfde_ctrl.sv
// Controller: request sequencing, box stepping, read-modify-write timing, result register.
`default_nettype none
`include "mono_framebuffer_draw_engine_defines.svh"
module mfde_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [7:0]         in_char_code,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mfde_pkg::dp_ctrl_t      ctl,
  input  wire mfde_pkg::dp_stat_t st
);
  import mfde_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_BOX, S_CLIP, S_RD, S_WR, S_NEXT, S_RDB, S_DONE
  } state_t;

  state_t     state_r;
  logic       init_r;
  logic       out_valid_r;
  logic [2:0] gcol_r, grow_r;
  logic       last_box;

  always_comb begin
    if (st.cmd == CMD_OUTLINE) begin
      last_box = (grow_r[1:0] == OUTLINE_LAST);
    end else if (st.cmd == CMD_CHAR || st.cmd == CMD_TEXT) begin
      last_box = (gcol_r == GLYPH_LCOL) && (grow_r == GLYPH_LROW);
    end else begin
      last_box = 1'b1;
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.gcol     = gcol_r;
    ctl.grow     = grow_r;
    ctl.load     = (state_r == S_IDLE) && in_valid;
    ctl.box_calc = (state_r == S_BOX);
    ctl.clip     = (state_r == S_CLIP);
    ctl.mem_rd   = (state_r == S_RD) || (state_r == S_RDB);
    ctl.rd_cmd   = (state_r == S_RDB);
    ctl.mem_wr   = (state_r == S_WR);
    ctl.adv      = (state_r == S_WR);
    ctl.out_load = (state_r == S_DONE) && !init_r && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOX;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      gcol_r      <= '0;
      grow_r      <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            gcol_r <= '0;
            grow_r <= '0;
            priority if (cmd_t'(in_cmd) == CMD_READ) begin
              state_r <= S_RDB;
            end else if (cmd_t'(in_cmd) == CMD_ORIGIN) begin
              state_r <= S_DONE;
            end else if (cmd_t'(in_cmd) == CMD_TEXT && in_char_code == CODE_NEWLINE) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_BOX;
            end
          end
        end
        S_BOX:  state_r <= st.glyph_skip ? S_NEXT : S_CLIP;
        S_CLIP: state_r <= st.box_empty ? S_NEXT : S_RD;
        S_RD:   state_r <= S_WR;
        S_WR:   state_r <= st.iter_last ? S_NEXT : S_RD;
        S_NEXT: begin
          if (last_box) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_BOX;
            // step down a glyph column, then move to the next column
            if ((st.cmd == CMD_CHAR || st.cmd == CMD_TEXT) && grow_r == GLYPH_LROW) begin
              grow_r <= '0;
              gcol_r <= gcol_r + 3'd1;
            end else begin
              grow_r <= grow_r + 3'd1;
            end
          end
        end
        S_RDB:  state_r <= S_DONE;
        S_DONE: begin
          if (init_r) begin
            init_r  <= 1'b0;
            state_r <= S_IDLE;
          end else if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `MFDE_ASSERT_NEXT(a_rd_then_wr, state_r == S_RD, state_r == S_WR)
  `MFDE_ASSERT_SAME(a_no_overrun, ctl.out_load, !out_valid_r || out_ready)
  `MFDE_ASSERT_SAME(a_init_blocks, init_r, !in_ready)
  `MFDE_ASSERT_NEXT(a_load_leaves_idle, ctl.load, state_r != S_IDLE)

endmodule
`default_nettype wire

FILE: rtl/mono_framebuffer_draw_engine.sv
// Top level of the monochrome page framebuffer draw engine.
//
// Use: one request per in_ handshake (valid/ready) carries a drawing command;
// every request returns exactly one result on the out_ channel, holding the
// store byte for a read of an address inside the store and zero for all
// others, in request order. Drawing is done one framebuffer byte at a time
// by read-modify-write through the single RAM port, after a box and a clip
// step for each box (one box per pixel, rectangle, outline edge or set glyph dot).
// One request is worked at a time; in_ready is high only while the engine is
// free, and it rises again while the last result still waits in the output
// register, so a new request can be worked during an output stall. A request
// that finishes while the output register is still full waits for it.
// After reset the engine sweeps the whole store to zero with in_ready low;
// cursor and text origin reset to zero.
`default_nettype none
module mono_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64,
  parameter int GLYPH_ADVANCE = 6,
  parameter int LINE_ADVANCE  = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_cmd,
  input  wire logic signed [15:0] in_x_pos,
  input  wire logic signed [15:0] in_y_pos,
  input  wire logic signed [15:0] in_rect_width,
  input  wire logic signed [15:0] in_rect_height,
  input  wire logic [7:0]         in_char_code,
  input  wire logic [7:0]         in_scale,
  input  wire logic               in_color,
  input  wire logic [9:0]         in_read_addr,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_read_data
);
  import mfde_pkg::*;

  dp_ctrl_t ctl;
  dp_stat_t st;

  mfde_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ctl          (ctl),
    .st           (st)
  );

  mfde_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .GLYPH_ADVANCE (GLYPH_ADVANCE),
    .LINE_ADVANCE  (LINE_ADVANCE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .st             (st),
    .in_cmd         (in_cmd),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_char_code   (in_char_code),
    .in_scale       (in_scale),
    .in_color       (in_color),
    .in_read_addr   (in_read_addr),
    .out_read_data  (out_read_data)
  );

endmodule
`default_nettype wire
